>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checking suspended while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/pli_pkg.sv
// constants, types and codes of the posting list intersection block
package pli_pkg;

    localparam int MAX_TERMS    = 4;
    localparam int LIST_DEPTH   = 1024;
    localparam int RESULT_LIMIT = 4;
    localparam int ACT_LIM      = (MAX_TERMS < RESULT_LIMIT) ? MAX_TERMS : RESULT_LIMIT;

    localparam int TERM_W      = $clog2(MAX_TERMS);
    localparam int IDX_W       = $clog2(LIST_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int ADDR_W      = TERM_W + IDX_W;
    localparam int STORE_DEPTH = MAX_TERMS * (2 ** IDX_W);

    localparam int OP_W   = 2;
    localparam int SLOT_W = 2;
    localparam int DOC_W  = 31;
    localparam int WT_W   = 32;
    localparam int CNT_W  = 3;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_FETCH = 2'd2;

    localparam logic STATUS_MATCH = 1'b0;
    localparam logic STATUS_DONE  = 1'b1;

    typedef logic [TERM_W-1:0] t_term;
    typedef logic [CNT_W-1:0]  t_cnt;

    // commands from the walker to the list bookkeeping
    typedef struct packed {
        logic                 load;
        logic                 first;
        logic [SLOT_W-1:0]    slot;
        logic [DOC_W-1:0]     doc;
        logic [WT_W-1:0]      weight;
        logic                 rewind;
        logic [MAX_TERMS-1:0] adv_mask;
        t_term                rd_term;
    } t_list_cmd;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DOC_W-1:0]  doc;
        logic [WT_W-1:0]   weight;
    } t_store_wr;

    typedef struct packed {
        logic             strobe;
        logic             status;
        logic [DOC_W-1:0] doc;
        logic [1:0]       term;
        logic [WT_W-1:0]  weight;
        logic             last;
    } t_result;

endpackage

>>> rtl/pli_store.sv
// entry memory: document id and weight of every list entry, one read and one write port
module pli_store import pli_pkg::*; (
    input  logic              i_clk,
    input  t_store_wr         i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DOC_W-1:0]  o_rd_doc,
    output logic [WT_W-1:0]   o_rd_weight
);

    logic [DOC_W+WT_W-1:0] mem [STORE_DEPTH];
    logic [DOC_W+WT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= {i_wr.doc, i_wr.weight};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_doc    = r_rd_data[DOC_W+WT_W-1:WT_W];
    assign o_rd_weight = r_rd_data[WT_W-1:0];

endmodule

>>> rtl/pli_lists.sv
// list lengths and cursors: appends entries, rewinds and advances cursors, flags exhausted lists
module pli_lists import pli_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_list_cmd            i_cmd,
    output t_store_wr            o_wr,
    output logic [ADDR_W-1:0]    o_rd_addr,
    output logic [MAX_TERMS-1:0] o_exhausted
);

    logic [LEN_W-1:0] r_len [MAX_TERMS];
    logic [LEN_W-1:0] r_cur [MAX_TERMS];

    logic             slot_ok;
    t_term            slot_t;
    logic [LEN_W-1:0] len_eff;
    logic             room;
    logic [LEN_W-1:0] rd_cur;

    always_comb begin
        slot_ok = int'(i_cmd.slot) < MAX_TERMS;
        slot_t  = TERM_W'(i_cmd.slot);
        len_eff = i_cmd.first ? '0 : r_len[slot_t];
        room    = len_eff < LEN_W'(LIST_DEPTH);

        o_wr.we     = i_cmd.load && slot_ok && room;
        o_wr.addr   = {slot_t, len_eff[IDX_W-1:0]};
        o_wr.doc    = i_cmd.doc;
        o_wr.weight = i_cmd.weight;

        rd_cur    = r_cur[i_cmd.rd_term];
        o_rd_addr = {i_cmd.rd_term, rd_cur[IDX_W-1:0]};

        // also past the end when a list was reloaded shorter
        for (int t = 0; t < MAX_TERMS; t++) begin
            o_exhausted[t] = (r_cur[t] >= r_len[t]) || (r_cur[t] >= LEN_W'(LIST_DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < MAX_TERMS; t++) begin
                r_len[t] <= '0;
                r_cur[t] <= '0;
            end
        end else begin
            if (i_cmd.load && slot_ok) begin
                r_len[slot_t] <= room ? len_eff + LEN_W'(1) : len_eff;
            end
            for (int t = 0; t < MAX_TERMS; t++) begin
                if (i_cmd.rewind) begin
                    r_cur[t] <= '0;
                end else if (i_cmd.adv_mask[t]) begin
                    r_cur[t] <= r_cur[t] + LEN_W'(1);
                end
            end
        end
    end

endmodule

>>> rtl/pli_walk.sv
// command decode and the fetch sequencer that walks the cursors through the entry memory
module pli_walk import pli_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [SLOT_W-1:0]    i_term_slot,
    input  logic [DOC_W-1:0]     i_entry_doc,
    input  logic [WT_W-1:0]      i_entry_weight,
    input  logic                 i_first_of_list,
    input  t_cnt                 i_n,
    input  logic [MAX_TERMS-1:0] i_exhausted,
    input  logic [DOC_W-1:0]     i_rd_doc,
    input  logic [WT_W-1:0]      i_rd_weight,
    output logic                 o_busy,
    output t_list_cmd            o_cmd,
    output t_result              o_res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]       r_state, n_state;
    t_term            r_term, n_term;
    t_term            r_low_term, n_low_term;
    logic [DOC_W-1:0] r_low_doc, n_low_doc;
    logic             r_same, n_same;
    logic [DOC_W-1:0] r_doc [MAX_TERMS];
    logic [WT_W-1:0]  r_wt  [MAX_TERMS];

    logic             r_strobe, n_strobe;
    logic             r_status, n_status;
    logic [DOC_W-1:0] r_out_doc, n_out_doc;
    logic [1:0]       r_out_term, n_out_term;
    logic [WT_W-1:0]  r_out_wt, n_out_wt;
    logic             r_out_last, n_out_last;

    logic [MAX_TERMS-1:0] act;
    t_term                last_term;
    logic                 accept;
    logic                 any_ex;

    always_comb begin
        for (int t = 0; t < MAX_TERMS; t++) begin
            act[t] = t < int'(i_n);
        end
        last_term = TERM_W'(i_n - t_cnt'(1));
        accept    = i_start && (r_state == S_IDLE);
        any_ex    = |(i_exhausted & act);

        o_cmd.load     = accept && (i_opcode == OP_LOAD);
        o_cmd.first    = i_first_of_list;
        o_cmd.slot     = i_term_slot;
        o_cmd.doc      = i_entry_doc;
        o_cmd.weight   = i_entry_weight;
        o_cmd.rewind   = accept && (i_opcode == OP_START);
        o_cmd.adv_mask = '0;
        o_cmd.rd_term  = '0;

        n_state    = r_state;
        n_term     = r_term;
        n_low_term = r_low_term;
        n_low_doc  = r_low_doc;
        n_same     = r_same;
        n_strobe   = 1'b0;
        n_status   = STATUS_MATCH;
        n_out_doc  = '0;
        n_out_term = '0;
        n_out_wt   = '0;
        n_out_last = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_opcode == OP_FETCH)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (any_ex) begin
                    n_strobe   = 1'b1;
                    n_status   = STATUS_DONE;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.rd_term = '0;
                    n_term        = '0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                // read data of term r_term is here, next term's read goes out
                if (r_term == '0) begin
                    n_low_doc  = i_rd_doc;
                    n_low_term = '0;
                    n_same     = 1'b1;
                end else begin
                    n_same = r_same && (i_rd_doc == r_low_doc);
                    if (i_rd_doc < r_low_doc) begin
                        n_low_doc  = i_rd_doc;
                        n_low_term = r_term;
                    end
                end
                o_cmd.rd_term = r_term + t_term'(1);
                if (r_term == last_term) begin
                    n_state = S_DECIDE;
                end else begin
                    n_term = r_term + t_term'(1);
                end
            end
            S_DECIDE: begin
                if (r_same) begin
                    n_term  = '0;
                    n_state = S_EMIT;
                end else begin
                    // ties go to the lowest term
                    o_cmd.adv_mask = MAX_TERMS'(1) << r_low_term;
                    n_state        = S_CHECK;
                end
            end
            S_EMIT: begin
                n_strobe   = 1'b1;
                n_status   = STATUS_MATCH;
                n_out_doc  = r_doc[r_term];
                n_out_term = 2'(r_term);
                n_out_wt   = r_wt[r_term];
                n_out_last = r_term == last_term;
                if (r_term == last_term) begin
                    o_cmd.adv_mask = act;
                    n_state        = S_IDLE;
                end else begin
                    n_term = r_term + t_term'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term     <= n_term;
        r_low_term <= n_low_term;
        r_low_doc  <= n_low_doc;
        r_same     <= n_same;
        r_status   <= n_status;
        r_out_doc  <= n_out_doc;
        r_out_term <= n_out_term;
        r_out_wt   <= n_out_wt;
        r_out_last <= n_out_last;
        if (r_state == S_SCAN) begin
            r_doc[r_term] <= i_rd_doc;
            r_wt[r_term]  <= i_rd_weight;
        end
    end

    assign o_busy        = r_state != S_IDLE;
    assign o_res.strobe  = r_strobe;
    assign o_res.status  = r_status;
    assign o_res.doc     = r_out_doc;
    assign o_res.term    = r_out_term;
    assign o_res.weight  = r_out_wt;
    assign o_res.last    = r_out_last;

endmodule

>>> rtl/posting_list_intersection.sv
// load and start items are taken while idle and leave busy low; a fetch steps the cursors (n = terms)
// each step reads one entry per cycle through the single read port of the entry memory
// a match then gives n results back to back, from the emit state after the decision through the output registers
// a done result is registered from the check that finds a list run out; results can't stall
// synchronous reset clears lengths, cursors and sets term_count to 1; entries stay undefined
module posting_list_intersection import pli_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [SLOT_W-1:0] i_term_slot,
    input  logic [DOC_W-1:0]  i_entry_doc,
    input  logic [WT_W-1:0]   i_entry_weight,
    input  logic              i_first_of_list,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    output logic              o_strobe,
    output logic              o_status,
    output logic [DOC_W-1:0]  o_match_doc,
    output logic [1:0]        o_match_term,
    output logic [WT_W-1:0]   o_match_weight,
    output logic              o_last_of_match
);

`include "assert_macros.svh"

    t_cnt                 r_term_count;
    t_cnt                 active_terms;
    t_list_cmd            cmd;
    t_store_wr            wr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [MAX_TERMS-1:0] exhausted;
    logic [DOC_W-1:0]     rd_doc;
    logic [WT_W-1:0]      rd_weight;
    t_result              res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= t_cnt'(1);
        end else if (i_cfg_we) begin
            r_term_count <= i_cfg_wdata;
        end
    end

    // zero counts as one term, large counts saturate
    always_comb begin
        if (r_term_count == '0) begin
            active_terms = t_cnt'(1);
        end else if (int'(r_term_count) > ACT_LIM) begin
            active_terms = t_cnt'(ACT_LIM);
        end else begin
            active_terms = r_term_count;
        end
    end

    pli_walk u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_opcode        (i_opcode),
        .i_term_slot     (i_term_slot),
        .i_entry_doc     (i_entry_doc),
        .i_entry_weight  (i_entry_weight),
        .i_first_of_list (i_first_of_list),
        .i_n             (active_terms),
        .i_exhausted     (exhausted),
        .i_rd_doc        (rd_doc),
        .i_rd_weight     (rd_weight),
        .o_busy          (busy),
        .o_cmd           (cmd),
        .o_res           (res)
    );

    pli_lists u_lists (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_wr        (wr),
        .o_rd_addr   (rd_addr),
        .o_exhausted (exhausted)
    );

    // writes happen only while idle; read data is used only during a fetch
    pli_store u_store (
        .i_clk       (i_clk),
        .i_wr        (wr),
        .i_rd_addr   (rd_addr),
        .o_rd_doc    (rd_doc),
        .o_rd_weight (rd_weight)
    );

    assign o_strobe        = res.strobe;
    assign o_status        = res.status;
    assign o_match_doc     = res.doc;
    assign o_match_term    = res.term;
    assign o_match_weight  = res.weight;
    assign o_last_of_match = res.last;

    `ASSERT_CLK(a_strobe_from_fetch, o_strobe |-> $past(busy), "result without a fetch in flight")
    `ASSERT_CLK(a_done_is_last, (o_strobe && (o_status == STATUS_DONE)) |-> o_last_of_match, "done item not marked last")
    `ASSERT_CLK(a_fetch_busy, (start && !busy && (i_opcode == OP_FETCH)) |=> busy, "fetch taken but block not busy")
    `ASSERT_NEVER(a_no_write_in_fetch, busy && wr.we, "entry memory written during a fetch")

endmodule

>>> test/posting_list_intersection_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the posting list intersection block
module posting_list_intersection_tb;
    import pli_pkg::*;

    localparam logic [OP_W-1:0]  OP_UNUSED     = 2'd3;
    localparam logic [DOC_W-1:0] DOC_TOP       = 31'h7FFF_FFFF;
    localparam logic [WT_W-1:0]  WT_TOP        = 32'hFFFF_FFFF;
    localparam int               SETTLE_CYCLES = 16;
    localparam int               CYCLE_LIMIT   = 300000;
    localparam int               RANDOM_ITEMS  = 260;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [DOC_W-1:0]  doc;
        logic [WT_W-1:0]   weight;
        logic              first_of;
    } t_cmd;

    typedef struct packed {
        logic             status;
        logic [DOC_W-1:0] doc;
        logic [1:0]       term;
        logic [WT_W-1:0]  weight;
        logic             last_of;
    } t_match;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_TERMS} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_cmd       cmd;
        logic [CNT_W-1:0] terms;
        t_match     want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_opcode;
    logic [SLOT_W-1:0] i_term_slot;
    logic [DOC_W-1:0]  i_entry_doc;
    logic [WT_W-1:0]   i_entry_weight;
    logic              i_first_of_list;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_wdata;
    logic              o_strobe;
    logic              o_status;
    logic [DOC_W-1:0]  o_match_doc;
    logic [1:0]        o_match_term;
    logic [WT_W-1:0]   o_match_weight;
    logic              o_last_of_match;

    posting_list_intersection dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_term_slot     (i_term_slot),
        .i_entry_doc     (i_entry_doc),
        .i_entry_weight  (i_entry_weight),
        .i_first_of_list (i_first_of_list),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_match_doc     (o_match_doc),
        .o_match_term    (o_match_term),
        .o_match_weight  (o_match_weight),
        .o_last_of_match (o_last_of_match)
    );

    // predictor copy of the lists, cursors and term count
    logic [DOC_W-1:0] doc_mem [MAX_TERMS][LIST_DEPTH];
    logic [WT_W-1:0]  wt_mem  [MAX_TERMS][LIST_DEPTH];
    int unsigned      list_len [MAX_TERMS];
    int unsigned      cur_pos  [MAX_TERMS];
    logic [CNT_W-1:0] term_reg;
    logic [7:0]       terms_seen;

    t_match walk_out[$];
    t_match pending_matches[$];
    t_match exp_m;
    t_row   script[$];

    int  errors;
    int  n_items;
    int  n_fetches;
    int  n_results;
    int  n_hits;
    int  n_done;
    int  cycle_count;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_cmd pack_cmd(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                      logic [DOC_W-1:0] doc, logic [WT_W-1:0] weight,
                                      logic first_of);
        t_cmd c;
        c.op       = op;
        c.slot     = slot;
        c.doc      = doc;
        c.weight   = weight;
        c.first_of = first_of;
        return c;
    endfunction

    function automatic t_match pack_match(logic status, logic [DOC_W-1:0] doc,
                                          logic [1:0] term, logic [WT_W-1:0] weight,
                                          logic last_of);
        t_match m;
        m.status  = status;
        m.doc     = doc;
        m.term    = term;
        m.weight  = weight;
        m.last_of = last_of;
        return m;
    endfunction

    function automatic t_row item_row(t_cmd c);
        t_row r;
        r.kind  = ROW_ITEM;
        r.cmd   = c;
        r.terms = '0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_row checked_row(t_cmd c, t_match want);
        t_row r;
        r.kind  = ROW_CHECKED;
        r.cmd   = c;
        r.terms = '0;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row terms_row(logic [CNT_W-1:0] v);
        t_row r;
        r.kind  = ROW_TERMS;
        r.cmd   = '0;
        r.terms = v;
        r.want  = '0;
        return r;
    endfunction

    function automatic void add_row(t_row r);
        script.insert(script.size(), r);
    endfunction

    // advance the cursor at the smallest id until all ids agree or a list runs out, and queue the result
    function automatic void walk_lists();
        int unsigned      n;
        int unsigned      low_t;
        logic [DOC_W-1:0] low_doc;
        logic [DOC_W-1:0] d;
        bit               same;
        n = (term_reg == 0) ? 1 : term_reg;
        if (n > ACT_LIM) n = ACT_LIM;
        while (1) begin
            for (int t = 0; t < n; t++) begin
                if (cur_pos[t] >= list_len[t] || cur_pos[t] >= LIST_DEPTH) begin
                    walk_out.insert(walk_out.size(),
                                    pack_match(STATUS_DONE, '0, 2'd0, '0, 1'b1));
                    return;
                end
            end
            low_doc = doc_mem[0][cur_pos[0]];
            low_t   = 0;
            same    = 1'b1;
            for (int t = 1; t < n; t++) begin
                d = doc_mem[t][cur_pos[t]];
                if (d != low_doc) same = 1'b0;
                // ties keep the lower term
                if (d < low_doc) begin
                    low_doc = d;
                    low_t   = t;
                end
            end
            if (same) begin
                for (int t = 0; t < n; t++) begin
                    walk_out.insert(walk_out.size(),
                                    pack_match(STATUS_MATCH, doc_mem[t][cur_pos[t]], 2'(t),
                                               wt_mem[t][cur_pos[t]], t == n - 1));
                    cur_pos[t]++;
                end
                return;
            end
            cur_pos[low_t]++;
        end
    endfunction

    function automatic void apply_cmd(t_cmd c);
        walk_out.delete();
        case (c.op)
            OP_LOAD: begin
                if (c.slot < MAX_TERMS) begin
                    if (c.first_of) list_len[c.slot] = 0;
                    // entries past a full list are dropped
                    if (list_len[c.slot] < LIST_DEPTH) begin
                        doc_mem[c.slot][list_len[c.slot]] = c.doc;
                        wt_mem[c.slot][list_len[c.slot]]  = c.weight;
                        list_len[c.slot]++;
                    end
                end
            end
            OP_START: begin
                for (int t = 0; t < MAX_TERMS; t++) cur_pos[t] = 0;
            end
            OP_FETCH: walk_lists();
            default: ;
        endcase
    endfunction

    task automatic send_cmd(input t_cmd c, input bit typed, input t_match want);
        @(negedge i_clk);
        if (!calm && $urandom_range(99, 0) < 16) begin
            start = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        start           = 1'b1;
        i_opcode        = c.op;
        i_term_slot     = c.slot;
        i_entry_doc     = c.doc;
        i_entry_weight  = c.weight;
        i_first_of_list = c.first_of;
        do @(posedge i_clk); while (busy);
        apply_cmd(c);
        if (typed) begin
            pending_matches.insert(pending_matches.size(), want);
        end else begin
            foreach (walk_out[k]) pending_matches.insert(pending_matches.size(), walk_out[k]);
        end
        if (c.op != OP_UNUSED) n_items++;
        if (c.op == OP_FETCH) n_fetches++;
    endtask

    // drop start and wait until the block has drained
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_matches.size() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_terms(input logic [CNT_W-1:0] v);
        settle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        term_reg    = v;
        terms_seen[v] = 1'b1;
    endtask

    // one query: fresh small lists, a rewind that noisy queries may skip, then fetches until done twice
    task automatic run_query(input int sess);
        int               n_len;
        bit               noisy;
        bit               done_seen;
        logic [DOC_W-1:0] base;
        logic [DOC_W-1:0] d;
        noisy     = ($urandom_range(9, 0) == 0);
        done_seen = 1'b0;
        write_terms((sess < 8) ? CNT_W'(sess) : CNT_W'($urandom_range(7, 0)));
        base = DOC_W'($urandom_range(32'h7FFF_FFC0, 0));
        for (int s = 0; s < MAX_TERMS; s++) begin
            n_len = $urandom_range(4, 1);
            d     = base + DOC_W'($urandom_range(2, 0));
            for (int k = 0; k < n_len; k++) begin
                // noisy queries load unsorted ids
                send_cmd(pack_cmd(OP_LOAD, SLOT_W'(s),
                                  noisy ? base + DOC_W'($urandom_range(12, 0)) : d,
                                  $urandom, k == 0), 1'b0, '0);
                d = d + DOC_W'($urandom_range(3, 1));
            end
        end
        if (!noisy || $urandom_range(1, 0))
            send_cmd(pack_cmd(OP_START, SLOT_W'($urandom), DOC_W'($urandom), $urandom,
                              1'($urandom)), 1'b0, '0);
        for (int f = 0; f < 40; f++) begin
            if (noisy && $urandom_range(3, 0) == 0) begin
                if ($urandom_range(1, 0))
                    send_cmd(pack_cmd(OP_UNUSED, SLOT_W'($urandom), DOC_W'($urandom),
                                      $urandom, 1'($urandom)), 1'b0, '0);
                else
                    send_cmd(pack_cmd(OP_LOAD, SLOT_W'($urandom),
                                      base + DOC_W'($urandom_range(12, 0)),
                                      $urandom, 1'($urandom_range(1, 0))), 1'b0, '0);
            end
            send_cmd(pack_cmd(OP_FETCH, SLOT_W'($urandom), DOC_W'($urandom), $urandom,
                              1'($urandom)), 1'b0, '0);
            if (walk_out.size() != 0 && walk_out[0].status == STATUS_DONE) begin
                if (done_seen) break;
                done_seen = 1'b1;
            end
        end
    endtask

    task automatic flag_mismatch(input string fname, input logic [WT_W-1:0] want,
                                 input logic [WT_W-1:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            n_results++;
            if (pending_matches.size() == 0) begin
                errors++;
                $display("%0t ns: result with nothing expected, got status %0h doc %0h",
                         $time, o_status, o_match_doc);
            end else begin
                exp_m = pending_matches.pop_front();
                if (exp_m.status == STATUS_DONE) n_done++;
                else n_hits++;
                if (o_status !== exp_m.status)
                    flag_mismatch("status", WT_W'(exp_m.status), WT_W'(o_status));
                if (o_match_doc !== exp_m.doc)
                    flag_mismatch("match_doc", WT_W'(exp_m.doc), WT_W'(o_match_doc));
                if (o_match_term !== exp_m.term)
                    flag_mismatch("match_term", WT_W'(exp_m.term), WT_W'(o_match_term));
                if (o_match_weight !== exp_m.weight)
                    flag_mismatch("match_weight", exp_m.weight, o_match_weight);
                if (o_last_of_match !== exp_m.last_of)
                    flag_mismatch("last_of_match", WT_W'(exp_m.last_of),
                                  WT_W'(o_last_of_match));
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int   target;
        int   sess;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = OP_LOAD;
        i_term_slot     = '0;
        i_entry_doc     = '0;
        i_entry_weight  = '0;
        i_first_of_list = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        calm            = 1'b0;
        errors          = 0;
        n_items         = 0;
        n_fetches       = 0;
        n_results       = 0;
        n_hits          = 0;
        n_done          = 0;
        term_reg        = 3'd1;
        terms_seen      = 8'b0000_0010;
        for (int t = 0; t < MAX_TERMS; t++) begin
            list_len[t] = 0;
            cur_pos[t]  = 0;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty lists, then a single-term walk at the top of the ranges
        add_row(checked_row(pack_cmd(OP_FETCH, 0, 0, 0, 0),
                            pack_match(STATUS_DONE, 0, 0, 0, 1)));
        add_row(item_row(pack_cmd(OP_LOAD, 0, DOC_TOP, WT_TOP, 1)));
        add_row(item_row(pack_cmd(OP_START, 0, 0, 0, 0)));
        add_row(checked_row(pack_cmd(OP_FETCH, 0, 0, 0, 0),
                            pack_match(STATUS_MATCH, DOC_TOP, 0, WT_TOP, 1)));
        add_row(checked_row(pack_cmd(OP_FETCH, 0, 0, 0, 0),
                            pack_match(STATUS_DONE, 0, 0, 0, 1)));
        add_row(checked_row(pack_cmd(OP_FETCH, 3, DOC_TOP, WT_TOP, 1),
                            pack_match(STATUS_DONE, 0, 0, 0, 1)));
        add_row(item_row(pack_cmd(OP_UNUSED, 3, DOC_TOP, WT_TOP, 1)));
        // term count zero acts as one
        add_row(terms_row(3'd0));
        add_row(item_row(pack_cmd(OP_START, 0, 0, 0, 0)));
        add_row(checked_row(pack_cmd(OP_FETCH, 0, 0, 0, 0),
                            pack_match(STATUS_MATCH, DOC_TOP, 0, WT_TOP, 1)));
        // two terms, doc and weight zero at the head of one list
        add_row(terms_row(3'd2));
        add_row(item_row(pack_cmd(OP_LOAD, 0, 0, 0, 1)));
        add_row(item_row(pack_cmd(OP_LOAD, 0, 5, 32'h0001_8000, 0)));
        add_row(item_row(pack_cmd(OP_LOAD, 0, 9, 32'h0000_4000, 0)));
        add_row(item_row(pack_cmd(OP_LOAD, 1, 5, 32'h0002_0000, 1)));
        add_row(item_row(pack_cmd(OP_LOAD, 1, 9, 32'h8000_0001, 0)));
        add_row(item_row(pack_cmd(OP_LOAD, 1, 12, 32'h0000_0001, 0)));
        add_row(item_row(pack_cmd(OP_START, 0, 0, 0, 0)));
        add_row(item_row(pack_cmd(OP_FETCH, 0, 0, 0, 0)));
        add_row(item_row(pack_cmd(OP_FETCH, 0, 0, 0, 0)));
        add_row(item_row(pack_cmd(OP_FETCH, 0, 0, 0, 0)));
        // count above four saturates; lists 2 and 3 still empty
        add_row(terms_row(3'd7));
        add_row(item_row(pack_cmd(OP_START, 0, 0, 0, 0)));
        add_row(checked_row(pack_cmd(OP_FETCH, 0, 0, 0, 0),
                            pack_match(STATUS_DONE, 0, 0, 0, 1)));
        // four terms with a tie on the way, list 2 unsorted
        add_row(item_row(pack_cmd(OP_LOAD, 2, 9, 32'h0003_0000, 1)));
        add_row(item_row(pack_cmd(OP_LOAD, 2, 4, 32'h0004_0000, 0)));
        add_row(item_row(pack_cmd(OP_LOAD, 3, 9, 32'h0005_0000, 1)));
        add_row(item_row(pack_cmd(OP_START, 0, 0, 0, 0)));
        add_row(item_row(pack_cmd(OP_FETCH, 0, 0, 0, 0)));
        // list 0 reloaded shorter than its cursor
        add_row(item_row(pack_cmd(OP_LOAD, 0, 9, 32'h0006_0000, 1)));
        add_row(checked_row(pack_cmd(OP_FETCH, 0, 0, 0, 0),
                            pack_match(STATUS_DONE, 0, 0, 0, 1)));

        foreach (script[r]) begin
            case (script[r].kind)
                ROW_TERMS:   write_terms(script[r].terms);
                ROW_CHECKED: send_cmd(script[r].cmd, 1'b1, script[r].want);
                default:     send_cmd(script[r].cmd, 1'b0, script[r].want);
            endcase
        end

        target = n_items + RANDOM_ITEMS;
        sess   = 0;
        while (n_items < target) begin
            // one stretch without any gaps
            calm = (n_items >= target - 200 && n_items < target - 120);
            run_query(sess);
            sess++;
        end
        calm = 1'b0;

        settle();
        $display("sent %0d items in %0d queries, %0d of them fetches", n_items, sess, n_fetches);
        $display("checked %0d results: %0d match entries, %0d done; term counts used %b",
                 n_results, n_hits, n_done, terms_seen);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
